// File: design/ssnf_pkg.sv
// ============================================================================
// ssnf_pkg
// Shared types and constants for the seven-segment number formatter: the
// word types of both channels, the data that moves from cell to cell, and
// the digit glyph table.
// ============================================================================
`default_nettype none

package ssnf_pkg;

	// Segment byte for a minus sign (only segment g lit, active low).
	localparam logic [7:0] SEG_MINUS = 8'hBF;
	// Segment byte for a blank position.
	localparam logic [7:0] SEG_BLANK = 8'hFF;
	// Decimal point bit, active high before inversion.
	localparam logic [7:0] SEG_DP    = 8'h80;

	// Reciprocal of ten for a 32-bit dividend: q = (m * RECIP_TEN) >> RECIP_SHIFT.
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Input word: value and decimal place count.
	typedef struct packed {
		logic signed [31:0] number;
		logic signed [3:0]  point_position;
	} number_word_t;

	// Output word: one display frame and the last marker.
	typedef struct packed {
		logic [15:0] frame;
		logic        last;
	} frame_word_t;

	// Data a cell holds and hands to its neighbor.
	typedef struct packed {
		logic [31:0]        mag;
		logic signed [3:0]  places;
		logic               neg;
	} cell_data_t;

	// Segment pattern of a decimal digit, active high (gfedcba).
	function automatic logic [7:0] glyph(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0:    seg = 8'h3F;
			4'd1:    seg = 8'h06;
			4'd2:    seg = 8'h5B;
			4'd3:    seg = 8'h4F;
			4'd4:    seg = 8'h66;
			4'd5:    seg = 8'h6D;
			4'd6:    seg = 8'h7D;
			4'd7:    seg = 8'h07;
			4'd8:    seg = 8'h7F;
			4'd9:    seg = 8'h6F;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

// File: design/ssnf_cell.sv
// ============================================================================
// ssnf_cell
// One digit cell of the formatter chain. It holds the remaining magnitude,
// the places count and the sign flag of the word passing through, produces
// the segment byte for its position and hands the reduced state onward.
// ============================================================================
`default_nettype none

module ssnf_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic                valid_d,
	input  wire ssnf_pkg::cell_data_t d,
	output logic                     valid_q,
	output ssnf_pkg::cell_data_t     nxt,
	output logic [7:0]               seg
);
	import ssnf_pkg::*;

	cell_data_t  data_q;
	logic [63:0] prod;
	logic [28:0] quot;
	logic [31:0] quot_x10;
	logic [31:0] rem;
	logic        show_digit;

	// Valid bit follows the load strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_d;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	// Divide the magnitude by ten through the reciprocal and take the remainder.
	always_comb begin
		prod     = {32'd0, data_q.mag} * {32'd0, RECIP_TEN};
		quot     = prod[63:RECIP_SHIFT];
		quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
		rem      = data_q.mag - quot_x10;
	end

	// A digit shows while magnitude remains or the point is still ahead.
	assign show_digit = (data_q.mag != 32'd0) || (data_q.places >= 4'sd0);

	// Segment byte for this position, active low.
	always_comb begin
		if (show_digit) begin
			seg = ~(glyph(rem[3:0]) | ((data_q.places == 4'sd0) ? SEG_DP : 8'h00));
		end else if (data_q.neg) begin
			seg = SEG_MINUS;
		end else begin
			seg = SEG_BLANK;
		end
	end

	// State handed to the next cell.
	always_comb begin
		nxt.mag    = {3'b000, quot};
		nxt.neg    = data_q.neg && show_digit;
		nxt.places = (data_q.places >= 4'sd0) ? (data_q.places - 4'sd1) : data_q.places;
	end

endmodule

`default_nettype wire

// File: design/seven_segment_number_formatter.sv
// ============================================================================
// seven_segment_number_formatter
// Turns a signed value and a decimal place count into display frames for a
// multiplexed seven-segment display, one frame per digit position.
// ============================================================================
//
// Usage: a word on the number channel (number_valid / number_stall) carries
// the value and the count of digits after the decimal point. For each word
// the block sends DIGITS words on the frame channel (frame_valid /
// frame_stall), least significant position first; last is set on the frame
// of the top position. Each frame has active-low segments in bits 15..8
// (decimal point at bit 15) and a one-hot digit select in bits 7..0.
// The word walks down a chain of DIGITS cells, one cell per cycle unless
// the receiver stalls; each cell makes the frame for its position and
// divides the magnitude by ten. The word enters the first cell when it is
// accepted, and the first frame passes from that cell into the output
// register; one frame leaves per cycle after that unless the receiver
// stalls. A new word is taken in the cycle its predecessor leaves the last
// cell, so the chain holds one word at a time. When the receiver stalls,
// the output register and the whole chain hold; the chain still takes a
// word while empty. Reset empties the chain and the output register.
// ============================================================================
`default_nettype none

module seven_segment_number_formatter #(
	parameter int DIGITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   number_valid,
	output logic                        number_stall,
	input  wire ssnf_pkg::number_word_t number_word,
	output logic                        frame_valid,
	input  wire logic                   frame_stall,
	output ssnf_pkg::frame_word_t       frame_word
);
	import ssnf_pkg::*;

	logic [DIGITS-1:0] valid;
	logic [DIGITS-1:0] load;
	logic [DIGITS-1:0] valid_d;
	cell_data_t        cell_d   [DIGITS];
	cell_data_t        cell_nxt [DIGITS];
	logic [7:0]        cell_seg [DIGITS];

	logic        any_valid;
	logic        advance;
	logic        take;
	cell_data_t  entry;
	logic [15:0] frame_sel;
	logic        last_sel;

	// The chain moves when it holds a word and the output register can load.
	assign any_valid    = |valid;
	assign advance      = any_valid && (!frame_valid || !frame_stall);
	assign number_stall = !((!any_valid) || (advance && valid[DIGITS-1]));
	assign take         = number_valid && !number_stall;

	// Entry data: magnitude taken as unsigned, sign kept as a flag.
	always_comb begin
		entry.neg    = number_word.number[31];
		entry.mag    = number_word.number[31] ? (32'd0 - number_word.number)
		                                      : number_word.number;
		entry.places = number_word.point_position;
	end

	// Chain of digit cells.
	for (genvar k = 0; k < DIGITS; k++) begin : g_cell
		if (k == 0) begin : g_first
			assign load[k]    = take || advance;
			assign valid_d[k] = take;
			assign cell_d[k]  = entry;
		end else begin : g_rest
			assign load[k]    = advance;
			assign valid_d[k] = valid[k-1];
			assign cell_d[k]  = cell_nxt[k-1];
		end

		ssnf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (load[k]),
			.valid_d (valid_d[k]),
			.d       (cell_d[k]),
			.valid_q (valid[k]),
			.nxt     (cell_nxt[k]),
			.seg     (cell_seg[k])
		);
	end

	// Pick the frame of the one active cell.
	always_comb begin
		frame_sel = 16'd0;
		for (int k = 0; k < DIGITS; k++) begin
			if (valid[k]) begin
				frame_sel = frame_sel | {cell_seg[k], 8'(1 << k)};
			end
		end
		last_sel = valid[DIGITS-1];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
		end else if (advance) begin
			frame_valid <= 1'b1;
		end else if (!frame_stall) begin
			frame_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_word.frame <= frame_sel;
			frame_word.last  <= last_sel;
		end
	end

endmodule

`default_nettype wire

// File: sim/tb_seven_segment_number_formatter.sv
// ============================================================================
// tb_seven_segment_number_formatter
// Self-checking testbench for the seven-segment number formatter. Every
// accepted number word is expanded here into the DIGITS display frames the
// block must send. A checker compares each frame word that leaves the block
// with the oldest frame still expected. Directed tests cover blanking, the
// extremes, the minus sign and the decimal point. The random tests then run
// under three patterns of sender and receiver idling.
// ============================================================================

module tb_seven_segment_number_formatter;

	timeunit 1ns;
	timeprecision 1ps;

	import ssnf_pkg::*;

	localparam int DIGITS      = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	// Active-high segment patterns of the decimal digits (gfedcba).
	localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic         clk;
	logic         arst_n;
	logic         number_valid;
	logic         number_stall;
	number_word_t number_word;
	logic         frame_valid;
	logic         frame_stall;
	frame_word_t  frame_word;

	frame_word_t  pending_frames[$];
	int           mismatch_count;
	int           send_idle_pct;
	int           stall_pct;

	seven_segment_number_formatter #(
		.DIGITS(DIGITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_valid(number_valid),
		.number_stall(number_stall),
		.number_word (number_word),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_word  (frame_word)
	);

	// Free-running clock, 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung run ends as a failure.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Expand one number word into the frames it must produce, least
	// significant position first.
	function automatic void format_number(input number_word_t word);
		logic [31:0] mag;
		logic        neg;
		int          places;
		logic [7:0]  seg;
		frame_word_t frame;
		neg = word.number[31];
		mag = word.number;
		if (neg)
			mag = 32'd0 - mag;
		places = {{28{word.point_position[3]}}, word.point_position};
		for (int pos = 0; pos < DIGITS; pos++) begin
			if (mag != 0 || places >= 0) begin
				seg = DIGIT_SEGMENTS[4'(mag % 10)];
				if (places == 0)
					seg = seg | SEG_DP;
				seg = ~seg;
			end else if (neg) begin
				// The sign takes the first free position, once.
				neg = 1'b0;
				seg = SEG_MINUS;
			end else begin
				seg = SEG_BLANK;
			end
			frame.frame = {seg, 8'(8'b1 << pos)};
			frame.last  = (pos == DIGITS - 1);
			pending_frames.push_back(frame);
			mag = mag / 10;
			if (places > -1)
				places--;
		end
	endfunction

	// Drive one number word, with a random gap first, and hold it until taken.
	task automatic send_number(input logic [31:0] value, input logic [3:0] places);
		number_word_t word;
		word.number         = value;
		word.point_position = places;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			number_valid <= 1'b0;
			@(posedge clk);
		end
		number_valid <= 1'b1;
		number_word  <= word;
		do
			@(posedge clk);
		while (number_stall);
		format_number(word);
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		frame_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Compare each accepted frame word with the oldest expected one.
	always @(posedge clk) begin
		frame_word_t want;
		if (arst_n && frame_valid && !frame_stall) begin
			if (pending_frames.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected frame word: frame %h last %b",
						frame_word.frame, frame_word.last);
			end else begin
				want = pending_frames.pop_front();
				if (frame_word.frame !== want.frame || frame_word.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("frame mismatch: expected %h/%b, got %h/%b",
							want.frame, want.last, frame_word.frame, frame_word.last);
				end
			end
		end
	end

	// Zero shows as all blank without a point, and as forced zeros with one.
	task automatic test_zero_and_blanking();
		send_number(32'd0, 4'hF);
		send_number(32'd0, 4'h8);
		send_number(32'd0, 4'd0);
		send_number(32'd0, 4'd7);
	endtask

	// Largest magnitudes, including the most negative value, and dropped digits.
	task automatic test_extremes();
		send_number(32'h7FFF_FFFF, 4'hF);
		send_number(32'h8000_0001, 4'd0);
		send_number(32'h8000_0000, 4'hF);
		send_number(32'h8000_0000, 4'd3);
		send_number(32'd99999999, 4'hF);
		send_number(32'd12345678, 4'd7);
	endtask

	// The minus sign appears once, after the digits, and is lost when they fill
	// every position.
	task automatic test_minus_sign();
		send_number(-32'sd5, 4'hF);
		send_number(-32'sd5, 4'd0);
		send_number(-32'sd5, 4'd4);
		send_number(-32'sd1234567, 4'hF);
		send_number(-32'sd12345678, 4'hF);
		send_number(-32'sd1, 4'd6);
		send_number(-32'sd3, 4'd7);
	endtask

	// Decimal point on interior positions, and other negative place counts.
	task automatic test_point_positions();
		send_number(32'd42, 4'd1);
		send_number(32'd42, 4'd5);
		send_number(32'd7, 4'hC);
		send_number(32'd100, 4'd2);
		send_number(-32'sd100, 4'hD);
	endtask

	// Random values of random digit count, sign and place count.
	task automatic test_random_numbers(input int count);
		int                width;
		logic [31:0]       mag;
		logic [3:0]        places;
		longint unsigned   scale;
		repeat (count) begin
			width = $urandom_range(0, 10);
			if (width == 10) begin
				mag = $urandom;
			end else begin
				scale = 1;
				repeat (width) scale = scale * 10;
				mag = 32'($urandom % scale);
			end
			if ($urandom_range(0, 1))
				mag = 32'd0 - mag;
			// Favor the plain no-point setting a little.
			if ($urandom_range(0, 3) == 0)
				places = 4'hF;
			else
				places = 4'($urandom_range(0, 15));
			send_number(mag, places);
		end
	endtask

	// Test sequence.
	initial begin
		arst_n         <= 1'b0;
		number_valid   <= 1'b0;
		number_word    <= '0;
		mismatch_count = 0;
		send_idle_pct  = 14;
		stall_pct      = 72;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_and_blanking();
		test_extremes();
		test_minus_sign();
		test_point_positions();
		test_random_numbers(60);

		send_idle_pct = 72;
		stall_pct     = 14;
		test_random_numbers(70);

		send_idle_pct = 0;
		stall_pct     = 0;
		test_random_numbers(70);
		number_valid <= 1'b0;

		// Drain, then give the block time to show any stray frame.
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (4 * DIGITS) @(posedge clk);

		if (mismatch_count == 0 && pending_frames.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: seven_segment_number_formatter.f
design/ssnf_pkg.sv
design/ssnf_cell.sv
design/seven_segment_number_formatter.sv
sim/tb_seven_segment_number_formatter.sv
